FILE: rtl/rdrm_pkg.sv
package rdrm_pkg;

    localparam int DATA_W          = 32;
    localparam int MINUTE_SLOTS    = 60;
    localparam int HOUR_SLOTS      = 24;
    localparam int HOUR_TICKS      = 60;
    localparam int MIH_W           = 6;
    localparam logic [DATA_W-1:0] THRESHOLD_RESET = 32'd10;

    typedef logic [DATA_W-1:0] data_t;

endpackage

FILE: rtl/rdrm_in_if.sv
interface rdrm_in_if;
    logic            valid;
    logic            ready;
    rdrm_pkg::data_t classified_total;

    modport source (output valid, output classified_total, input ready);
    modport sink   (input valid, input classified_total, output ready);
endinterface

FILE: rtl/rdrm_out_if.sv
interface rdrm_out_if;
    logic            valid;
    logic            ready;
    rdrm_pkg::data_t rate_last_hour;
    rdrm_pkg::data_t rate_last_day;
    logic            hour_rolled;
    logic            decline_warning;

    modport source (output valid, output rate_last_hour, output rate_last_day,
                    output hour_rolled, output decline_warning, input ready);
    modport sink   (input valid, input rate_last_hour, input rate_last_day,
                    input hour_rolled, input decline_warning, output ready);
endinterface

FILE: rtl/rdrm_cfg_if.sv
interface rdrm_cfg_if;
    logic            valid;
    logic            ready;
    rdrm_pkg::data_t decline_threshold;

    modport source (output valid, output decline_threshold, input ready);
    modport sink   (input valid, input decline_threshold, output ready);
endinterface

FILE: rtl/rolling_decode_rate_monitor.sv
// rolling decode-rate monitor: each accepted tick word carries the running frame count at
// a minute boundary; the delta to the previous tick goes into the minute ring, every 60th
// tick the minute-ring total is archived into the hour ring, and one result word per tick
// reports the last-hour rate, the last-day rate, the hour roll flag and the decline warning.
// from acceptance a tick steps through S_MSUM, S_HWR (only on an hour roll), S_HSUM, S_FIN
// and S_OUT to the result register, with a single shared 32-bit adder that walks the minute
// ring and then the hour ring one slot per cycle through the registered read port of each
// ring ram. ticks.ready is high only while the sequencer is idle; a finished result may wait
// in the output register while the next tick is accepted. both rings read as zero after
// reset (per-slot valid bits), so no clearing pass is needed.
// cfg.ready is always high; the threshold should only be written while no tick is in flight.
module rolling_decode_rate_monitor #(
    parameter int MINUTE_SLOTS = rdrm_pkg::MINUTE_SLOTS,
    parameter int HOUR_SLOTS   = rdrm_pkg::HOUR_SLOTS
) (
    input  logic       clk,
    input  logic       rst_n,
    rdrm_in_if.sink    ticks,
    rdrm_out_if.source rates,
    rdrm_cfg_if.sink   cfg
);

    localparam int DW       = rdrm_pkg::DATA_W;
    localparam int MW       = (MINUTE_SLOTS > 1) ? $clog2(MINUTE_SLOTS) : 1;
    localparam int HW       = (HOUR_SLOTS > 1) ? $clog2(HOUR_SLOTS) : 1;
    localparam int MAX_SLOTS = (MINUTE_SLOTS > HOUR_SLOTS) ? MINUTE_SLOTS : HOUR_SLOTS;
    localparam int CW       = $clog2(MAX_SLOTS + 1);
    localparam int MIH_W    = rdrm_pkg::MIH_W;

    localparam logic [MW-1:0]    M_LAST      = MW'(MINUTE_SLOTS - 1);
    localparam logic [HW-1:0]    H_LAST      = HW'(HOUR_SLOTS - 1);
    localparam logic [CW-1:0]    M_END       = CW'(MINUTE_SLOTS);
    localparam logic [CW-1:0]    H_END       = CW'(HOUR_SLOTS);
    localparam logic [MIH_W-1:0] LAST_MINUTE = MIH_W'(rdrm_pkg::HOUR_TICKS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MSUM = 3'd1;
    localparam logic [2:0] S_HWR  = 3'd2;
    localparam logic [2:0] S_HSUM = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    rdrm_pkg::data_t         acc_reg, acc_next;
    rdrm_pkg::data_t         sum1h_reg, sum1h_next;
    rdrm_pkg::data_t         prev_reg, prev_next;
    rdrm_pkg::data_t         thr_reg;
    logic [MW-1:0]           m_head_reg, m_head_next;
    logic [HW-1:0]           h_head_reg, h_head_next;
    logic [MIH_W-1:0]        mih_reg, mih_next;
    logic                    rolled_reg, rolled_next;
    logic [MINUTE_SLOTS-1:0] m_vld_reg;
    logic [HOUR_SLOTS-1:0]   h_vld_reg;
    logic                    m_rvld_reg;
    logic                    h_rvld_reg;
    logic                    h_skip_reg;

    logic                    out_valid_reg;
    rdrm_pkg::data_t         out_hour_reg;
    rdrm_pkg::data_t         out_day_reg;
    logic                    out_rolled_reg;
    logic                    out_warn_reg;

    logic                    accept;
    logic                    out_free;
    logic [MW-1:0]           m_head_inc;
    logic [HW-1:0]           h_head_inc;
    logic [MW-1:0]           m_raddr;
    logic [HW-1:0]           h_raddr;
    rdrm_pkg::data_t         m_rdata;
    rdrm_pkg::data_t         h_rdata;
    logic                    m_we;
    logic                    h_we;
    rdrm_pkg::data_t         delta;
    rdrm_pkg::data_t         add_b;
    rdrm_pkg::data_t         add_sum;
    logic                    warn;

    assign accept     = ticks.valid && ticks.ready;
    assign ticks.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign out_free    = !out_valid_reg || rates.ready;

    assign m_head_inc = (m_head_reg == M_LAST) ? '0 : m_head_reg + MW'(1);
    assign h_head_inc = (h_head_reg == H_LAST) ? '0 : h_head_reg + HW'(1);
    assign delta      = ticks.classified_total - prev_reg;

    // sweep addresses, parked at zero once the counter passes the last slot
    assign m_raddr = (cnt_reg < M_END) ? cnt_reg[MW-1:0] : '0;
    assign h_raddr = (cnt_reg < H_END) ? cnt_reg[HW-1:0] : '0;

    assign m_we = accept;
    assign h_we = (state_reg == S_HWR);

    rdrm_ram #(
        .WIDTH (DW),
        .DEPTH (MINUTE_SLOTS)
    ) u_minute_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_head_inc),
        .wdata (delta),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    rdrm_ram #(
        .WIDTH (DW),
        .DEPTH (HOUR_SLOTS)
    ) u_hour_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_head_inc),
        .wdata (sum1h_reg),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // shared adder operand select; unwritten slots read as zero
    always_comb
    begin
        case (state_reg)
            S_MSUM:  add_b = m_rvld_reg ? m_rdata : '0;
            S_HSUM:  add_b = (h_rvld_reg && !h_skip_reg) ? h_rdata : '0;
            S_FIN:   add_b = sum1h_reg;
            default: add_b = '0;
        endcase
    end

    assign add_sum = acc_reg + add_b;
    assign warn    = rolled_reg && (acc_reg > thr_reg) && (sum1h_reg == '0);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        sum1h_next  = sum1h_reg;
        prev_next   = prev_reg;
        m_head_next = m_head_reg;
        h_head_next = h_head_reg;
        mih_next    = mih_reg;
        rolled_next = rolled_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_next   = ticks.classified_total;
                    m_head_next = m_head_inc;
                    rolled_next = (mih_reg == LAST_MINUTE);
                    mih_next    = (mih_reg == LAST_MINUTE) ? '0 : mih_reg + MIH_W'(1);
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = S_MSUM;
                end
            end
            S_MSUM:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = add_sum;
                end
                if (cnt_reg == M_END)
                begin
                    sum1h_next = add_sum;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = rolled_reg ? S_HWR : S_HSUM;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_HWR:
            begin
                h_head_next = h_head_inc;
                state_next  = S_HSUM;
            end
            S_HSUM:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = add_sum;
                end
                if (cnt_reg == H_END)
                begin
                    cnt_next   = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_FIN:
            begin
                // day rate: hour slots other than head plus the last hour
                acc_next   = add_sum;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            thr_reg       <= rdrm_pkg::THRESHOLD_RESET;
            m_head_reg    <= '0;
            h_head_reg    <= '0;
            mih_reg       <= '0;
            rolled_reg    <= 1'b0;
            m_vld_reg     <= '0;
            h_vld_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            prev_reg   <= prev_next;
            m_head_reg <= m_head_next;
            h_head_reg <= h_head_next;
            mih_reg    <= mih_next;
            rolled_reg <= rolled_next;
            if (cfg.valid && cfg.ready)
            begin
                thr_reg <= cfg.decline_threshold;
            end
            if (m_we)
            begin
                m_vld_reg[m_head_inc] <= 1'b1;
            end
            if (h_we)
            begin
                h_vld_reg[h_head_inc] <= 1'b1;
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rates.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sum1h_reg  <= sum1h_next;
        m_rvld_reg <= m_vld_reg[m_raddr];
        h_rvld_reg <= h_vld_reg[h_raddr];
        h_skip_reg <= (h_raddr == h_head_reg);
        if (state_reg == S_OUT && out_free)
        begin
            out_hour_reg   <= sum1h_reg;
            out_day_reg    <= acc_reg;
            out_rolled_reg <= rolled_reg;
            out_warn_reg   <= warn;
        end
    end

    assign rates.valid           = out_valid_reg;
    assign rates.rate_last_hour  = out_hour_reg;
    assign rates.rate_last_day   = out_day_reg;
    assign rates.hour_rolled     = out_rolled_reg;
    assign rates.decline_warning = out_warn_reg;

endmodule

FILE: rtl/rdrm_ram.sv
module rdrm_ram #(
    parameter int WIDTH = rdrm_pkg::DATA_W,
    parameter int DEPTH = rdrm_pkg::MINUTE_SLOTS
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: verif/tb_rolling_decode_rate_monitor.sv
`timescale 1ns / 100ps

module tb_rolling_decode_rate_monitor;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int END_WAIT    = 200;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        rdrm_pkg::data_t last_hour;
        rdrm_pkg::data_t last_day;
        logic            rolled;
        logic            warn;
    } rate_word_t;

    typedef enum int {
        HOUR_QUIET,
        HOUR_BUSY,
        HOUR_SPARSE,
        HOUR_NOISE,
        HOUR_LARGE,
        HOUR_WRAP
    } hour_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    rdrm_in_if  tick_if ();
    rdrm_out_if rate_if ();
    rdrm_cfg_if cfg_if ();

    rolling_decode_rate_monitor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .ticks (tick_if),
        .rates (rate_if),
        .cfg   (cfg_if)
    );

    always #10 clk = ~clk;

    // shadow of the monitor state
    rdrm_pkg::data_t minute_slots [rdrm_pkg::MINUTE_SLOTS];
    rdrm_pkg::data_t hour_slots [rdrm_pkg::HOUR_SLOTS];
    int              minute_pos;
    int              hour_pos;
    int              minutes_done;
    rdrm_pkg::data_t last_total;
    rdrm_pkg::data_t threshold_now;

    rate_word_t      expected_rates[$];
    rate_word_t      rate_due;
    rdrm_pkg::data_t running_total;
    int              err_count;
    int              cycle_count;
    int              burst_left;
    bit              tx_calm;
    bit              rx_calm;
    int              rx_hold;
    int              rx_stall;

    function automatic rdrm_pkg::data_t sum_minute_slots();
        rdrm_pkg::data_t acc;
        acc = '0;
        for (int i = 0; i < rdrm_pkg::MINUTE_SLOTS; i++)
            acc += minute_slots[i];
        return acc;
    endfunction

    task automatic predict_tick(input rdrm_pkg::data_t total);
        rate_word_t      w;
        rdrm_pkg::data_t hour_total;
        rdrm_pkg::data_t all_hours;
        w = '0;
        minute_pos = (minute_pos + 1) % rdrm_pkg::MINUTE_SLOTS;
        minute_slots[minute_pos] = total - last_total;
        last_total = total;
        minutes_done++;
        if (minutes_done >= rdrm_pkg::HOUR_TICKS)
        begin
            minutes_done = 0;
            hour_total = sum_minute_slots();
            hour_pos = (hour_pos + 1) % rdrm_pkg::HOUR_SLOTS;
            hour_slots[hour_pos] = hour_total;
            all_hours = '0;
            for (int i = 0; i < rdrm_pkg::HOUR_SLOTS; i++)
                all_hours += hour_slots[i];
            w.rolled = 1'b1;
            w.warn = (all_hours > threshold_now) && (hour_total == '0);
        end
        w.last_hour = sum_minute_slots();
        w.last_day = w.last_hour;
        // the head hour slot is covered by the live minute ring
        for (int i = 0; i < rdrm_pkg::HOUR_SLOTS; i++)
            if (i != hour_pos)
                w.last_day += hour_slots[i];
        expected_rates.push_back(w);
    endtask

    task automatic report_mismatch(input string what, input rdrm_pkg::data_t got,
                                   input rdrm_pkg::data_t want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        err_count++;
    endtask

    task automatic send_tick(input rdrm_pkg::data_t total);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = 0;
            if (!tx_calm && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 120);
            if (gap != 0)
            begin
                tick_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tick_if.valid <= 1'b1;
        tick_if.classified_total <= total;
        do
            @(posedge clk);
        while (!tick_if.ready);
        predict_tick(total);
    endtask

    // stop offering words and wait for every outstanding result
    task automatic finish_pending();
        tick_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_rates.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_threshold(input rdrm_pkg::data_t value);
        cfg_if.valid <= 1'b1;
        cfg_if.decline_threshold <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        threshold_now = value;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_first_ticks();
        rdrm_pkg::data_t totals [10];
        // first delta is the full count, then a wrap of the running count
        totals = '{32'hFFFF_FFFF, 32'h0000_0004, 32'h0000_0004, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0000_0001, 32'hFFFF_FFFE};
        tx_calm = 1'b0;
        foreach (totals[i])
            send_tick(totals[i]);
        running_total = totals[9];
    endtask

    task automatic test_output_hold();
        tx_calm = 1'b1;
        rx_hold = HOLD_CYCLES;
        for (int k = 0; k < 8; k++)
        begin
            running_total += $urandom_range(0, 50);
            send_tick(running_total);
        end
        finish_pending();
        tx_calm = 1'b0;
    endtask

    task automatic send_hour(input hour_mode_t mode);
        int              count;
        rdrm_pkg::data_t step;
        count = rdrm_pkg::HOUR_TICKS - minutes_done;
        tx_calm = ($urandom_range(0, 5) == 0);
        rx_calm = ($urandom_range(0, 5) == 0);
        if (mode == HOUR_WRAP)
            running_total = 32'hFFFF_FFFF - $urandom_range(0, 400);
        for (int k = 0; k < count; k++)
        begin
            case (mode)
                HOUR_QUIET:  step = '0;
                HOUR_BUSY:   step = $urandom_range(0, 20);
                HOUR_SPARSE: step = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 0;
                HOUR_LARGE:  step = $urandom() | 32'h4000_0000;
                HOUR_WRAP:   step = $urandom_range(0, 30);
                default:     step = $urandom() - running_total;
            endcase
            running_total += step;
            send_tick(running_total);
        end
    endtask

    task automatic test_random_hours();
        rdrm_pkg::data_t thresholds [6];
        hour_mode_t      mode;
        int              r;
        thresholds = '{rdrm_pkg::THRESHOLD_RESET, 32'h0000_0000, 32'hFFFF_FFFF,
                       rdrm_pkg::data_t'($urandom_range(0, 3000)),
                       rdrm_pkg::data_t'($urandom()), 32'd10};
        for (int p = 0; p < 6; p++)
        begin
            // first phase runs on the reset value of the threshold
            if (p != 0)
            begin
                finish_pending();
                write_threshold(thresholds[p]);
            end
            for (int h = 0; h < 5; h++)
            begin
                r = $urandom_range(0, 19);
                if (r < 5)
                    mode = HOUR_QUIET;
                else if (r < 10)
                    mode = HOUR_BUSY;
                else if (r < 13)
                    mode = HOUR_SPARSE;
                else if (r < 16)
                    mode = HOUR_NOISE;
                else if (r < 18)
                    mode = HOUR_LARGE;
                else
                    mode = HOUR_WRAP;
                send_hour(mode);
            end
        end
        rx_calm = 1'b0;
        tx_calm = 1'b0;
    endtask

    // result side: stalls on its own pattern, plus the long hold-off
    initial
    begin
        rate_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold != 0)
            begin
                rx_hold--;
                rate_if.ready <= 1'b0;
            end
            else if (rx_calm)
                rate_if.ready <= 1'b1;
            else if (rx_stall != 0)
            begin
                rx_stall--;
                rate_if.ready <= 1'b0;
            end
            else
            begin
                rate_if.ready <= 1'b1;
                if ($urandom_range(0, 29) == 0)
                    rx_stall = $urandom_range(1, 100);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rate_if.valid && rate_if.ready)
        begin
            if (expected_rates.size() == 0)
                report_mismatch("unexpected result word, last_hour", rate_if.rate_last_hour, '0);
            else
            begin
                rate_due = expected_rates.pop_front();
                if (rate_if.rate_last_hour !== rate_due.last_hour)
                    report_mismatch("rate_last_hour", rate_if.rate_last_hour, rate_due.last_hour);
                if (rate_if.rate_last_day !== rate_due.last_day)
                    report_mismatch("rate_last_day", rate_if.rate_last_day, rate_due.last_day);
                if (rate_if.hour_rolled !== rate_due.rolled)
                    report_mismatch("hour_rolled", rdrm_pkg::data_t'(rate_if.hour_rolled),
                                    rdrm_pkg::data_t'(rate_due.rolled));
                if (rate_if.decline_warning !== rate_due.warn)
                    report_mismatch("decline_warning",
                                    rdrm_pkg::data_t'(rate_if.decline_warning),
                                    rdrm_pkg::data_t'(rate_due.warn));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        tick_if.valid <= 1'b0;
        tick_if.classified_total <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.decline_threshold <= '0;
        rst_n <= 1'b0;
        foreach (minute_slots[i])
            minute_slots[i] = '0;
        foreach (hour_slots[i])
            hour_slots[i] = '0;
        minute_pos = 0;
        hour_pos = 0;
        minutes_done = 0;
        last_total = '0;
        threshold_now = rdrm_pkg::THRESHOLD_RESET;
        running_total = '0;
        err_count = 0;
        cycle_count = 0;
        burst_left = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        rx_hold = 0;
        rx_stall = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_ticks();
        test_output_hold();
        test_random_hours();

        finish_pending();
        repeat (END_WAIT) @(posedge clk);
        if (expected_rates.size() != 0)
            report_mismatch("results never delivered",
                            rdrm_pkg::data_t'(expected_rates.size()), '0);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
